// ===== rtl/fmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fmd_pkg: shared types and constants of the framed message deframer
//
// Holds the decoder phase encoding, the result kinds, the register indexes,
// the configuration bundle and the result bundle used between modules.
// ----------------------------------------------------------------------------
package fmd_pkg;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_SYNC  = 2'd0,
		REG_SECOND_SYNC = 2'd1,
		REG_GAP_TIMEOUT = 2'd2,
		REG_MAX_LEN     = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [7:0] FIRST_SYNC_RST  = 8'd52;
	localparam logic [7:0] SECOND_SYNC_RST = 8'd68;
	localparam logic [7:0] GAP_TIMEOUT_RST = 8'd100;
	localparam logic [7:0] MAX_LEN_RST     = 8'd255;

	// Number of header bytes: length, id, version
	localparam logic [7:0] HEADER_BYTES = 8'd3;

	// Idle counter saturation value
	localparam logic [7:0] IDLE_MAX = 8'd255;

	// Input flag values
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Decoder phase; unused codes behave as the first preamble hunt
	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_HEADER  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHK_LO  = 3'd4,
		PH_CHK_HI  = 3'd5
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BAD      = 2'd2,
		KIND_OVERSIZE = 2'd3
	} kind_t;

	// Configuration bundle
	typedef struct packed {
		logic [7:0] first_sync;
		logic [7:0] second_sync;
		logic [7:0] gap_timeout;
		logic [7:0] max_len;
	} cfg_t;

	// Result payload, packed with the last field in the lowest bits
	typedef struct packed {
		logic [15:0] bad_total;
		logic [15:0] good_total;
		logic [7:0]  msg_length;
		logic [7:0]  msg_version;
		logic [7:0]  msg_id;
		logic [7:0]  byte_index;
		logic [7:0]  payload_byte;
	} res_data_t;

	localparam int unsigned RES_DATA_W = $bits(res_data_t);

endpackage

// ===== rtl/fmd_cfg.sv =====
// ----------------------------------------------------------------------------
// fmd_cfg: configuration registers
//
// Four 8-bit registers written through a plain write port, no read-back.
// ----------------------------------------------------------------------------
module fmd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	output fmd_pkg::cfg_t                  cfg
);

	fmd_pkg::cfg_t cfg_q;

	// Register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_sync  <= fmd_pkg::FIRST_SYNC_RST;
			cfg_q.second_sync <= fmd_pkg::SECOND_SYNC_RST;
			cfg_q.gap_timeout <= fmd_pkg::GAP_TIMEOUT_RST;
			cfg_q.max_len     <= fmd_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			case (fmd_pkg::cfg_reg_t'(cfg_index))
				fmd_pkg::REG_FIRST_SYNC:  cfg_q.first_sync  <= cfg_data;
				fmd_pkg::REG_SECOND_SYNC: cfg_q.second_sync <= cfg_data;
				fmd_pkg::REG_GAP_TIMEOUT: cfg_q.gap_timeout <= cfg_data;
				fmd_pkg::REG_MAX_LEN:     cfg_q.max_len     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/fmd_core.sv =====
// ----------------------------------------------------------------------------
// fmd_core: frame decoder state and per-beat update
//
// Holds the phase, header fields, modulo-256 Fletcher-style sums, idle timer and frame
// counters. The state registers take one beat's update whenever en is high; the
// result is presented combinationally for the output register.
// ----------------------------------------------------------------------------
module fmd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 action,
	input  logic [7:0]           rx_byte,
	input  fmd_pkg::cfg_t        cfg,
	output logic                 res_valid,
	output fmd_pkg::kind_t       res_kind,
	output fmd_pkg::res_data_t   res_data
);

	fmd_pkg::phase_t phase_q, phase_d, phase_eff;
	logic [7:0]  bytes_q, bytes_d, bytes_inc;
	logic [7:0]  hdr_id_q, hdr_id_d;
	logic [7:0]  hdr_ver_q, hdr_ver_d;
	logic [7:0]  hdr_len_q, hdr_len_d;
	logic [7:0]  sum_lo_q, sum_lo_d, sum_lo_acc;
	logic [7:0]  sum_hi_q, sum_hi_d, sum_hi_acc;
	logic [7:0]  idle_q, idle_d;
	logic [15:0] good_q, good_d;
	logic [15:0] bad_q, bad_d;

	// Running sums with this byte folded in
	assign sum_lo_acc = sum_lo_q + rx_byte;
	assign sum_hi_acc = sum_hi_q + sum_lo_acc;
	assign bytes_inc  = bytes_q + 8'd1;

	// Gap timeout forces the preamble hunt before the byte is decoded
	assign phase_eff = (idle_q > cfg.gap_timeout) ? fmd_pkg::PH_SYNC1 : phase_q;

	// Next state
	always_comb begin
		phase_d   = phase_q;
		bytes_d   = bytes_q;
		hdr_id_d  = hdr_id_q;
		hdr_ver_d = hdr_ver_q;
		hdr_len_d = hdr_len_q;
		sum_lo_d  = sum_lo_q;
		sum_hi_d  = sum_hi_q;
		idle_d    = idle_q;
		good_d    = good_q;
		bad_d     = bad_q;
		if (action == fmd_pkg::ACT_TICK) begin
			if (idle_q != fmd_pkg::IDLE_MAX) begin
				idle_d = idle_q + 8'd1;
			end
		end else begin
			idle_d  = '0;
			phase_d = phase_eff;
			case (phase_eff)
				fmd_pkg::PH_SYNC2: begin
					if (rx_byte == cfg.second_sync) begin
						phase_d  = fmd_pkg::PH_HEADER;
						bytes_d  = '0;
						sum_lo_d = '0;
						sum_hi_d = '0;
					end else if (rx_byte == cfg.first_sync) begin
						phase_d = fmd_pkg::PH_SYNC2;
					end else begin
						phase_d = fmd_pkg::PH_SYNC1;
					end
				end
				fmd_pkg::PH_HEADER: begin
					sum_lo_d = sum_lo_acc;
					sum_hi_d = sum_hi_acc;
					if (bytes_q == 8'd0) begin
						hdr_len_d = rx_byte;
					end else if (bytes_q == 8'd1) begin
						hdr_id_d = rx_byte;
					end else begin
						hdr_ver_d = rx_byte;
					end
					bytes_d = bytes_inc;
					if (bytes_inc >= fmd_pkg::HEADER_BYTES) begin
						bytes_d = '0;
						if (hdr_len_d > cfg.max_len) begin
							phase_d = fmd_pkg::PH_SYNC1;
						end else if (hdr_len_d == 8'd0) begin
							phase_d = fmd_pkg::PH_CHK_LO;
						end else begin
							phase_d = fmd_pkg::PH_PAYLOAD;
						end
					end
				end
				fmd_pkg::PH_PAYLOAD: begin
					sum_lo_d = sum_lo_acc;
					sum_hi_d = sum_hi_acc;
					bytes_d  = bytes_inc;
					if (bytes_inc == hdr_len_q) begin
						phase_d = fmd_pkg::PH_CHK_LO;
					end
				end
				fmd_pkg::PH_CHK_LO: begin
					if (rx_byte != sum_lo_q) begin
						bad_d   = bad_q + 16'd1;
						phase_d = fmd_pkg::PH_SYNC1;
					end else begin
						phase_d = fmd_pkg::PH_CHK_HI;
					end
				end
				fmd_pkg::PH_CHK_HI: begin
					phase_d = fmd_pkg::PH_SYNC1;
					if (rx_byte == sum_hi_q) begin
						good_d = good_q + 16'd1;
					end else begin
						bad_d = bad_q + 16'd1;
					end
				end
				default: begin
					phase_d = (rx_byte == cfg.first_sync) ? fmd_pkg::PH_SYNC2
						: fmd_pkg::PH_SYNC1;
				end
			endcase
		end
	end

	// Result decode
	always_comb begin
		res_valid              = 1'b0;
		res_kind               = fmd_pkg::KIND_PAYLOAD;
		res_data.payload_byte  = '0;
		res_data.byte_index    = '0;
		res_data.msg_id        = hdr_id_d;
		res_data.msg_version   = hdr_ver_d;
		res_data.msg_length    = hdr_len_d;
		res_data.good_total    = good_d;
		res_data.bad_total     = bad_d;
		if (action == fmd_pkg::ACT_BYTE) begin
			case (phase_eff)
				fmd_pkg::PH_HEADER: begin
					if (bytes_inc >= fmd_pkg::HEADER_BYTES && hdr_len_d > cfg.max_len) begin
						res_valid = 1'b1;
						res_kind  = fmd_pkg::KIND_OVERSIZE;
					end
				end
				fmd_pkg::PH_PAYLOAD: begin
					res_valid             = 1'b1;
					res_kind              = fmd_pkg::KIND_PAYLOAD;
					res_data.payload_byte = rx_byte;
					res_data.byte_index   = bytes_q;
				end
				fmd_pkg::PH_CHK_LO: begin
					if (rx_byte != sum_lo_q) begin
						res_valid = 1'b1;
						res_kind  = fmd_pkg::KIND_BAD;
					end
				end
				fmd_pkg::PH_CHK_HI: begin
					res_valid = 1'b1;
					res_kind  = (rx_byte == sum_hi_q) ? fmd_pkg::KIND_GOOD
						: fmd_pkg::KIND_BAD;
				end
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fmd_pkg::PH_SYNC1;
			bytes_q   <= '0;
			hdr_id_q  <= '0;
			hdr_ver_q <= '0;
			hdr_len_q <= '0;
			sum_lo_q  <= '0;
			sum_hi_q  <= '0;
			idle_q    <= '0;
			good_q    <= '0;
			bad_q     <= '0;
		end else if (en) begin
			phase_q   <= phase_d;
			bytes_q   <= bytes_d;
			hdr_id_q  <= hdr_id_d;
			hdr_ver_q <= hdr_ver_d;
			hdr_len_q <= hdr_len_d;
			sum_lo_q  <= sum_lo_d;
			sum_hi_q  <= sum_hi_d;
			idle_q    <= idle_d;
			good_q    <= good_d;
			bad_q     <= bad_d;
		end
	end

endmodule

// ===== rtl/framed_message_deframer.sv =====
// ----------------------------------------------------------------------------
// framed_message_deframer: preamble-framed message decoder, modulo-256 Fletcher-style check
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | tdata: rx_byte; tuser: action
// m_      | out | m_tvalid/m_tready  | tdata: result fields; tuser: kind
// cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// One beat per cycle sustained while no result waits on m_tready. A beat is
// taken into the input register and decoded into the output register when the
// decode stage advances; a beat that yields a result then shows it on m_tvalid.
// While a result waits on m_tready the decode stage holds; the input register
// still takes one beat if it was empty, then s_tready drops until it drains.
// Reset clears the phase, counters, sums and configuration to defaults.
// ----------------------------------------------------------------------------
module framed_message_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [7:0] rx_byte
	input  logic [0:0]                          s_tuser,  // [0] action
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] payload_byte, [15:8] byte_index, [23:16] msg_id,
	// [31:24] msg_version, [39:32] msg_length, [55:40] good_total,
	// [71:56] bad_total
	output logic [fmd_pkg::RES_DATA_W-1:0]      m_tdata,
	output logic [1:0]                          m_tuser,  // [1:0] kind
	// configuration
	input  logic                                cfg_we,
	input  logic [fmd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [7:0]                          cfg_data
);

	fmd_pkg::cfg_t      cfg;
	fmd_pkg::kind_t     res_kind;
	fmd_pkg::res_data_t res_data;
	logic               res_valid;

	logic       vld_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic       in_beat;
	logic       adv;

	logic               m_vld_q;
	logic [1:0]         m_kind_q;
	fmd_pkg::res_data_t m_data_q;

	// Decode stage moves when the output register is free or draining
	assign adv      = vld_s1 && (!m_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign in_beat  = s_tvalid && s_tready;

	fmd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fmd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.action    (action_s1),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_kind  (res_kind),
		.res_data  (res_data)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_beat) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			action_s1 <= s_tuser[0];
			byte_s1   <= s_tdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (adv) begin
			m_vld_q <= res_valid;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			m_kind_q <= res_kind;
			m_data_q <= res_data;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;

endmodule

// ===== dv/framed_message_deframer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_message_deframer_test: self-checking bench for the message deframer
//
// A clocked driver feeds bytes and millisecond ticks from a queue of pending
// beats. A cycle-free decoder model predicts payload, good, bad and oversize
// results as each beat is accepted. A clocked monitor compares every result
// beat field by field with the oldest prediction. Both sides idle at random.
// The sync bytes, the gap timeout and the length limit are rewritten between
// phases once all predicted results have drained.
// ----------------------------------------------------------------------------
module framed_message_deframer_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 4;

	typedef struct packed {
		logic       act;
		logic [7:0] rx;
	} rx_item_t;

	typedef struct packed {
		fmd_pkg::kind_t     kind;
		fmd_pkg::res_data_t data;
	} frame_res_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_CHK_LO,
		FLAW_CHK_HI,
		FLAW_CUT
	} frame_flaw_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = '0;
	logic [0:0]                     s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [fmd_pkg::RES_DATA_W-1:0] m_tdata;
	logic [1:0]                     m_tuser;
	logic                           cfg_we    = 1'b0;
	logic [fmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [7:0]                     cfg_data  = '0;

	framed_message_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Decoder model state and its copy of the registers
	fmd_pkg::cfg_t   shadow_cfg;
	fmd_pkg::phase_t dec_phase;
	logic [7:0]      hdr_pos;
	logic [7:0]      hdr_len;
	logic [7:0]      hdr_id;
	logic [7:0]      hdr_ver;
	logic [7:0]      sum_lo;
	logic [7:0]      sum_hi;
	logic [7:0]      idle_ticks;
	logic [15:0]     good_cnt;
	logic [15:0]     bad_cnt;

	rx_item_t   rx_items[$];
	frame_res_t expected_results[$];
	rx_item_t   cur_item;
	int         queued      = 0;
	int         mismatches  = 0;
	int         send_wait   = 0;
	int         recv_wait   = 0;
	int         quiet_cycles = 0;
	bit         send_burst  = 1'b0;
	bit         recv_burst  = 1'b0;

	// Advance the decoder by one beat; returns 1 when a result is produced
	function automatic bit decode_item(input rx_item_t it, output frame_res_t res);
		bit emits;
		emits = 1'b0;
		res = '0;
		if (it.act == fmd_pkg::ACT_TICK) begin
			if (idle_ticks != fmd_pkg::IDLE_MAX)
				idle_ticks = idle_ticks + 8'd1;
			return 1'b0;
		end
		// long silence drops back to the preamble hunt
		if (idle_ticks > shadow_cfg.gap_timeout)
			dec_phase = fmd_pkg::PH_SYNC1;
		idle_ticks = '0;
		case (dec_phase)
			fmd_pkg::PH_SYNC2: begin
				if (it.rx == shadow_cfg.second_sync) begin
					dec_phase = fmd_pkg::PH_HEADER;
					hdr_pos = '0;
					sum_lo = '0;
					sum_hi = '0;
				end else begin
					// a wrong second byte may itself open a preamble
					dec_phase = (it.rx == shadow_cfg.first_sync) ? fmd_pkg::PH_SYNC2
						: fmd_pkg::PH_SYNC1;
				end
			end
			fmd_pkg::PH_HEADER: begin
				sum_lo = sum_lo + it.rx;
				sum_hi = sum_hi + sum_lo;
				if (hdr_pos == 8'd0)
					hdr_len = it.rx;
				else if (hdr_pos == 8'd1)
					hdr_id = it.rx;
				else
					hdr_ver = it.rx;
				hdr_pos = hdr_pos + 8'd1;
				if (hdr_pos >= fmd_pkg::HEADER_BYTES) begin
					hdr_pos = '0;
					if (hdr_len > shadow_cfg.max_len) begin
						dec_phase = fmd_pkg::PH_SYNC1;
						res.kind = fmd_pkg::KIND_OVERSIZE;
						emits = 1'b1;
					end else begin
						dec_phase = (hdr_len == 8'd0) ? fmd_pkg::PH_CHK_LO
							: fmd_pkg::PH_PAYLOAD;
					end
				end
			end
			fmd_pkg::PH_PAYLOAD: begin
				res.kind = fmd_pkg::KIND_PAYLOAD;
				res.data.payload_byte = it.rx;
				res.data.byte_index = hdr_pos;
				sum_lo = sum_lo + it.rx;
				sum_hi = sum_hi + sum_lo;
				hdr_pos = hdr_pos + 8'd1;
				if (hdr_pos == hdr_len)
					dec_phase = fmd_pkg::PH_CHK_LO;
				emits = 1'b1;
			end
			fmd_pkg::PH_CHK_LO: begin
				if (it.rx != sum_lo) begin
					// high checksum byte is not awaited
					bad_cnt = bad_cnt + 16'd1;
					dec_phase = fmd_pkg::PH_SYNC1;
					res.kind = fmd_pkg::KIND_BAD;
					emits = 1'b1;
				end else begin
					dec_phase = fmd_pkg::PH_CHK_HI;
				end
			end
			fmd_pkg::PH_CHK_HI: begin
				dec_phase = fmd_pkg::PH_SYNC1;
				if (it.rx == sum_hi) begin
					good_cnt = good_cnt + 16'd1;
					res.kind = fmd_pkg::KIND_GOOD;
				end else begin
					bad_cnt = bad_cnt + 16'd1;
					res.kind = fmd_pkg::KIND_BAD;
				end
				emits = 1'b1;
			end
			default: begin
				dec_phase = (it.rx == shadow_cfg.first_sync) ? fmd_pkg::PH_SYNC2
					: fmd_pkg::PH_SYNC1;
			end
		endcase
		if (emits) begin
			res.data.msg_id      = hdr_id;
			res.data.msg_version = hdr_ver;
			res.data.msg_length  = hdr_len;
			res.data.good_total  = good_cnt;
			res.data.bad_total   = bad_cnt;
		end
		return emits;
	endfunction

	// Compare one result beat with the oldest prediction
	function automatic void check_result(input logic [1:0] got_kind,
			input fmd_pkg::res_data_t got);
		frame_res_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected result beat: kind %0d data %h", got_kind, got);
			return;
		end
		want = expected_results.pop_front();
		if (got_kind !== want.kind || got !== want.data) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("mismatch exp: kind %0d byte %h idx %0d id %h ver %h len %0d",
					want.kind, want.data.payload_byte, want.data.byte_index,
					want.data.msg_id, want.data.msg_version, want.data.msg_length);
				$display("              good %0d bad %0d",
					want.data.good_total, want.data.bad_total);
				$display("         got: kind %0d byte %h idx %0d id %h ver %h len %0d",
					got_kind, got.payload_byte, got.byte_index, got.msg_id,
					got.msg_version, got.msg_length);
				$display("              good %0d bad %0d", got.good_total, got.bad_total);
			end
		end
	endfunction

	// Input driver: predicts on every accepted beat, then loads the next one
	always @(posedge clk or negedge arst_n) begin : byte_driver
		frame_res_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (decode_item(cur_item, res))
					expected_results.push_back(res);
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0 || rx_items.size() == 0) begin
					if (send_wait > 0)
						send_wait--;
					s_tvalid <= 1'b0;
				end else begin
					cur_item = rx_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_item.rx;
					s_tuser  <= cur_item.act;
					if ($urandom_range(0, 63) == 0)
						send_burst = !send_burst;
					send_wait = send_burst ? 0 : $urandom_range(0, 6);
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin : result_monitor
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tuser, m_tdata);
				if ($urandom_range(0, 63) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 6);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("FAIL framed_message_deframer");
		$finish;
	end

	function automatic void push_byte(input logic [7:0] b);
		rx_items.push_back({fmd_pkg::ACT_BYTE, b});
		queued++;
	endfunction

	function automatic void push_ticks(input int n);
		repeat (n) begin
			rx_items.push_back({fmd_pkg::ACT_TICK, 8'($urandom)});
			queued++;
		end
	endfunction

	// Preamble, header, payload and checksum, optionally damaged or cut short
	function automatic void push_frame(input logic [7:0] len, input logic [7:0] id,
			input logic [7:0] ver, input frame_flaw_t flaw, input bit jitter);
		logic [7:0] body[$];
		logic [7:0] lo;
		logic [7:0] hi;
		int         cut_at;
		lo = '0;
		hi = '0;
		body.push_back(shadow_cfg.first_sync);
		body.push_back(shadow_cfg.second_sync);
		body.push_back(len);
		body.push_back(id);
		body.push_back(ver);
		repeat (len) body.push_back(8'($urandom));
		for (int i = 2; i < body.size(); i++) begin
			lo = lo + body[i];
			hi = hi + lo;
		end
		if (flaw == FLAW_CHK_LO)
			lo = lo ^ 8'($urandom_range(1, 255));
		if (flaw == FLAW_CHK_HI)
			hi = hi ^ 8'($urandom_range(1, 255));
		body.push_back(lo);
		body.push_back(hi);
		cut_at = (flaw == FLAW_CUT) ? $urandom_range(1, body.size() - 1) : body.size();
		for (int i = 0; i < cut_at; i++) begin
			if (jitter && $urandom_range(0, 24) == 0)
				push_ticks($urandom_range(1, 2));
			push_byte(body[i]);
		end
	endfunction

	// Mostly well-formed frames with random content, plus noise and silences
	function automatic void queue_random_traffic(input int n);
		int          stop_at;
		int          pick;
		logic [7:0]  len;
		frame_flaw_t flaw;
		stop_at = queued + n;
		while (queued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 29) == 0)
					len = 8'($urandom_range(0, 255));
				else
					len = 8'($urandom_range(0, 8));
				pick = $urandom_range(0, 99);
				if (pick < 10)
					flaw = FLAW_CHK_LO;
				else if (pick < 20)
					flaw = FLAW_CHK_HI;
				else if (pick < 26)
					flaw = FLAW_CUT;
				else
					flaw = FLAW_NONE;
				push_frame(len, 8'($urandom), 8'($urandom), flaw, 1'b1);
			end else if (pick < 82) begin
				repeat ($urandom_range(1, 4))
					push_byte(($urandom_range(0, 3) == 0) ? shadow_cfg.first_sync
						: 8'($urandom));
			end else if (pick < 94) begin
				push_ticks($urandom_range(1, 3));
			end else begin
				// silence long enough to force a resync where that is cheap
				push_ticks((shadow_cfg.gap_timeout < 8'd40) ? shadow_cfg.gap_timeout + 1 : 1);
			end
		end
	endfunction

	// Wait until every beat is sent and every predicted result has come
	task automatic wait_idle();
		do @(negedge clk);
		while (rx_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input fmd_pkg::cfg_reg_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			fmd_pkg::REG_FIRST_SYNC:  shadow_cfg.first_sync  = val;
			fmd_pkg::REG_SECOND_SYNC: shadow_cfg.second_sync = val;
			fmd_pkg::REG_GAP_TIMEOUT: shadow_cfg.gap_timeout = val;
			fmd_pkg::REG_MAX_LEN:     shadow_cfg.max_len     = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [7:0] sync_a, input logic [7:0] sync_b,
			input logic [7:0] timeout, input logic [7:0] max_len);
		wait_idle();
		write_reg(fmd_pkg::REG_FIRST_SYNC, sync_a);
		write_reg(fmd_pkg::REG_SECOND_SYNC, sync_b);
		write_reg(fmd_pkg::REG_GAP_TIMEOUT, timeout);
		write_reg(fmd_pkg::REG_MAX_LEN, max_len);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		shadow_cfg = '{fmd_pkg::FIRST_SYNC_RST, fmd_pkg::SECOND_SYNC_RST,
			fmd_pkg::GAP_TIMEOUT_RST, fmd_pkg::MAX_LEN_RST};
		dec_phase  = fmd_pkg::PH_SYNC1;
		hdr_pos    = '0;
		hdr_len    = '0;
		hdr_id     = '0;
		hdr_ver    = '0;
		sum_lo     = '0;
		sum_hi     = '0;
		idle_ticks = '0;
		good_cnt   = '0;
		bad_cnt    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: hunt noise, empty good frame, repeated first sync with bad low sum
		push_ticks(1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_frame(8'd0, 8'hFF, 8'h00, FLAW_NONE, 1'b0);
		push_byte(shadow_cfg.first_sync);
		push_frame(8'd1, 8'h00, 8'hFF, FLAW_CHK_LO, 1'b0);
		queue_random_traffic(150);

		// low extremes: oversize drop, empty frame, gap timeout, bad high sum
		apply_setting(8'h00, 8'hFF, 8'd1, 8'd0);
		push_frame(8'd1, 8'h5A, 8'h3C, FLAW_NONE, 1'b0);
		push_ticks(2);
		push_frame(8'd0, 8'h01, 8'h02, FLAW_NONE, 1'b0);
		push_byte(8'h00);
		push_ticks(2);
		push_byte(8'hFF);
		push_frame(8'd0, 8'h03, 8'h04, FLAW_CHK_HI, 1'b0);
		queue_random_traffic(180);

		// high extremes: longest payload and a saturated idle counter
		apply_setting(8'hFF, 8'h00, 8'd254, 8'd255);
		push_frame(8'd255, 8'hC3, 8'h81, FLAW_NONE, 1'b0);
		push_byte(8'hFF);
		push_ticks(255);
		push_byte(8'h00);
		queue_random_traffic(120);

		apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(1, 254)),
			8'($urandom_range(4, 20)));
		queue_random_traffic(200);

		// identical preamble bytes
		apply_setting(8'hA5, 8'hA5, 8'd10, 8'd8);
		queue_random_traffic(180);

		apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(1, 30)),
			8'($urandom));
		queue_random_traffic(180);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS framed_message_deframer");
		else
			$display("FAIL framed_message_deframer");
		$finish;
	end

endmodule

// ===== framed_message_deframer.f =====
rtl/fmd_pkg.sv
rtl/fmd_cfg.sv
rtl/fmd_core.sv
rtl/framed_message_deframer.sv
dv/framed_message_deframer_test.sv
